// File: src/oqt_pkg.sv
package oqt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int QTY_BITS    = 32;
	localparam int ID_W        = 32;
	localparam int KEY_W       = 64;
	localparam int IN_QTY_W    = 32;
	localparam int TOTAL_W     = 38;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// stream payload widths
	localparam int S_DATA_W = 128;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 80;
	localparam int M_USER_W = 2;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REDUCE = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic                flag;
		logic [KEY_W-1:0]    key;
		logic [QTY_BITS-1:0] qty;
		logic [ID_W-1:0]     id;
	} entry_t;

	// low QTY_BITS of the request quantity, zero-extended where QTY_BITS is wider
	function automatic logic [QTY_BITS-1:0] qty_from_req(input logic [IN_QTY_W-1:0] q);
		logic [QTY_BITS+IN_QTY_W-1:0] w;
		w = '0;
		w[IN_QTY_W-1:0] = q;
		return w[QTY_BITS-1:0];
	endfunction

	// quantity brought to the width of the totals (modulo 2^TOTAL_W)
	function automatic logic [TOTAL_W-1:0] qty_to_total(input logic [QTY_BITS-1:0] q);
		logic [QTY_BITS+TOTAL_W-1:0] w;
		w = '0;
		w[QTY_BITS-1:0] = q;
		return w[TOTAL_W-1:0];
	endfunction

endpackage

// File: src/order_level_quantity_table_top.sv
// Order table for one price level, up to TABLE_DEPTH resting orders. A request is
// taken only while the block is idle; it then walks the stored entries one per
// cycle through a single registered read port, comparing ids (add, reduce,
// remove stop at the first hit) or accumulating quantities not owned by the
// given key (query). When an entry is deleted, the last entry is read back
// and moved into the freed slot. The response sits in an output register, so
// the next request may be taken while it waits.
module order_level_quantity_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// id [31:0], order_qty [63:32], owner_key [127:64]
	input  logic [oqt_pkg::S_DATA_W-1:0]  s_tdata,
	// opcode [1:0], owner_present [2]
	input  logic [oqt_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// full_total [37:0], partial_total [75:38], zero [79:76]
	output logic [oqt_pkg::M_DATA_W-1:0]  m_tdata,
	// status [1:0]
	output logic [oqt_pkg::M_USER_W-1:0]  m_tuser
);
	import oqt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_ACT  = 6'b000100,
		S_LAST = 6'b001000,
		S_MOVE = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [ID_W-1:0]     id_q;
	logic [QTY_BITS-1:0] qty_q;
	logic [KEY_W-1:0]    key_q;
	logic                present_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  partial_q;
	logic                found_q;
	logic [IDX_W-1:0]    slot_q;
	entry_t              found_rec_q;
	status_t             status_q;

	logic                m_tvalid_q;
	logic [TOTAL_W-1:0]  out_full_q;
	logic [TOTAL_W-1:0]  out_partial_q;
	status_t             out_status_q;

	entry_t              mem_q [TABLE_DEPTH];
	entry_t              rd_data_s1;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;

	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;

	logic                hit;
	logic                scan_done;
	logic                table_full;
	logic                add_ok;
	logic                upd_ok;
	logic [CNT_W-1:0]    last_cnt;
	entry_t              new_rec;
	entry_t              upd_rec;

	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(M_DATA_W - 2*TOTAL_W){1'b0}}, out_partial_q, out_full_q};
	assign m_tuser   = out_status_q;

	assign last_cnt   = count_q - CNT_W'(1);
	assign table_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign hit        = rd_vld_s1 && !found_q && (op_q != OP_QUERY) && (rd_data_s1.id == id_q);
	assign scan_done  = !rd_vld_s1 && (found_q || idx_q >= count_q);
	assign add_ok     = (state_q == S_ACT) && (op_q == OP_ADD) && !found_q && !table_full;
	assign upd_ok     = (state_q == S_ACT) && (op_q == OP_REDUCE) && found_q && (qty_q != '0);

	always_comb begin
		new_rec.flag = present_q;
		new_rec.key  = present_q ? key_q : '0;
		new_rec.qty  = qty_q;
		new_rec.id   = id_q;
		upd_rec      = found_rec_q;
		upd_rec.qty  = qty_q;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		if (state_q == S_SCAN) begin
			rd_en = (idx_q < count_q) && !found_q;
		end else if (state_q == S_LAST) begin
			rd_en   = 1'b1;
			rd_addr = last_cnt[IDX_W-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = upd_rec;
		if (add_ok) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IDX_W-1:0];
			wr_data = new_rec;
		end else if (upd_ok) begin
			wr_en = 1'b1;
		end else if (state_q == S_MOVE) begin
			wr_en   = 1'b1;
			wr_data = rd_data_s1;
		end
	end

	// entry store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		rd_idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			total_q   <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			idx_q     <= '0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) && rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (hit) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					state_q <= S_RESP;
					unique case (op_q)
						OP_ADD: begin
							if (add_ok) begin
								count_q <= count_q + CNT_W'(1);
								total_q <= total_q + qty_to_total(qty_q);
							end
						end
						OP_REDUCE, OP_REMOVE: begin
							if (found_q) begin
								if (upd_ok) begin
									total_q <= total_q - qty_to_total(found_rec_q.qty)
										+ qty_to_total(qty_q);
								end else begin
									total_q <= total_q - qty_to_total(found_rec_q.qty);
									state_q <= S_LAST;
								end
							end
						end
						OP_QUERY: begin
						end
						default: begin
						end
					endcase
				end
				S_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					count_q <= last_cnt;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request fields, scan results and status
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q      <= op_t'(s_tuser[1:0]);
			present_q <= s_tuser[2];
			id_q      <= s_tdata[ID_W-1:0];
			qty_q     <= qty_from_req(s_tdata[ID_W +: IN_QTY_W]);
			key_q     <= s_tdata[ID_W+IN_QTY_W +: KEY_W];
			partial_q <= '0;
		end
		if (hit) begin
			slot_q      <= rd_idx_s1;
			found_rec_q <= rd_data_s1;
		end
		if (state_q == S_SCAN && rd_vld_s1 && op_q == OP_QUERY) begin
			if (!(rd_data_s1.flag && rd_data_s1.key == key_q)) begin
				partial_q <= partial_q + qty_to_total(rd_data_s1.qty);
			end
		end
		if (state_q == S_ACT) begin
			unique case (op_q)
				OP_ADD: begin
					if (found_q) begin
						status_q <= ST_DUP;
					end else if (table_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
					end
				end
				OP_REDUCE, OP_REMOVE: begin
					status_q <= found_q ? ST_OK : ST_MISSING;
				end
				OP_QUERY: begin
					status_q <= ST_OK;
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_RESP && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!m_tvalid_q || m_tready)) begin
			out_status_q  <= status_q;
			out_full_q    <= total_q;
			out_partial_q <= (op_q == OP_QUERY) ? partial_q : '0;
		end
	end

endmodule

// File: src/oqt_check.sv
module oqt_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [oqt_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [oqt_pkg::M_USER_W-1:0]  m_tuser
);
	import oqt_pkg::*;

	logic s_fire;
	assign s_fire = s_tvalid && s_tready;

	// a stalled response holds
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("response changed while stalled");

	// the block is busy for at least the cycle after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("request taken while busy");

	// error statuses come only from add, reduce or remove: no partial total
	a_err_partial: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[2*TOTAL_W-1:TOTAL_W] == '0)
		else $error("partial total on an error response");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:2*TOTAL_W] == '0)
		else $error("padding bits set");

endmodule

bind order_level_quantity_table_top oqt_check u_oqt_check (.*);
